// ----- design/adcu_pkg.sv -----
package adcu_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int HELD_BITS      = 48;
    localparam int WORD_BITS      = 64;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int PARAM_BITS     = 31;
    localparam int SCH_BITS       = 2;
    localparam int MOP_BITS       = 4;

    typedef logic signed [WORD_BITS-1:0] word_t;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_SCHEME      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIFFUSIVITY = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_INV_DX      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_INV_DY      = 3'd4;

    // convection schemes
    localparam logic [SCH_BITS-1:0] SCH_CENTRAL = 2'd0;
    localparam logic [SCH_BITS-1:0] SCH_UPWIND  = 2'd1;
    localparam logic [SCH_BITS-1:0] SCH_QUICK   = 2'd2;
    localparam logic [SCH_BITS-1:0] SCH_TVD     = 2'd3;

    // multiplier operations issued by the controller
    localparam logic [MOP_BITS-1:0] MOP_VFP  = 4'd0;
    localparam logic [MOP_BITS-1:0] MOP_VFN  = 4'd1;
    localparam logic [MOP_BITS-1:0] MOP_CP1  = 4'd2;
    localparam logic [MOP_BITS-1:0] MOP_CP2  = 4'd3;
    localparam logic [MOP_BITS-1:0] MOP_MH   = 4'd4;
    localparam logic [MOP_BITS-1:0] MOP_HH   = 4'd5;
    localparam logic [MOP_BITS-1:0] MOP_COEF = 4'd6;
    localparam logic [MOP_BITS-1:0] MOP_DIFF = 4'd7;
    localparam logic [MOP_BITS-1:0] MOP_TS   = 4'd8;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t HELD_MAX = (64'sd1 <<< (HELD_BITS-1)) - 64'sd1;
    localparam word_t HELD_MIN = -HELD_MAX - 64'sd1;

    typedef struct packed {
        logic                accept;
        logic                prep;
        logic                mul_start;
        logic [MOP_BITS-1:0] mul_op;
        logic                div_start;
        logic                div_neg;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic tvd_p;
        logic tvd_n;
        logic is_y;
        logic mul_done;
        logic div_done;
        logic out_free;
    } stat_t;

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t clamp_held(input word_t x);
        if (x > HELD_MAX)
            return HELD_MAX;
        if (x < HELD_MIN)
            return HELD_MIN;
        return x;
    endfunction

    // 0.75a + 0.375b - 0.125d, floored
    function automatic word_t quick_face(input word_t a, input word_t b, input word_t d);
        word_t t;
        t = (a <<< 2) + (a <<< 1) + (b <<< 1) + b - d;
        return t >>> 3;
    endfunction

endpackage

// ----- design/adcu_mul.sv -----
module adcu_mul
    import adcu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    output logic  done,
    output word_t res
);

    logic [WORD_BITS-1:0]   ua_reg, ub_reg;
    logic                   neg_reg;
    logic [2*WORD_BITS-1:0] acc_reg, acc_next;
    logic [1:0]             cnt_reg;
    logic                   busy_reg, fin_reg, done_reg;
    word_t                  res_reg, res_next;

    logic [31:0]            ai, bj;
    logic [63:0]            pp;
    logic [1:0]             sh;
    logic [2*WORD_BITS-1:0] q, qn;

    // one 32x32 partial product per cycle, low halves first
    always_comb
    begin
        ai       = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        bj       = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp       = ai * bj;
        sh       = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        acc_next = acc_reg + ({64'd0, pp} << {sh, 5'd0});
    end

    // shift out the fraction, floor toward minus infinity, saturate
    always_comb
    begin
        q  = acc_reg >> FRAC_BITS;
        qn = q + (2*WORD_BITS)'(neg_reg & (|acc_reg[FRAC_BITS-1:0]));
        if (!neg_reg)
            res_next = (|q[2*WORD_BITS-1:WORD_BITS-1]) ? WORD_MAX : word_t'(q[WORD_BITS-1:0]);
        else
            res_next = (|qn[2*WORD_BITS-1:WORD_BITS-1]) ? WORD_MIN
                                                        : word_t'(64'd0 - qn[WORD_BITS-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= busy_reg && (cnt_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= a[WORD_BITS-1] ? (64'd0 - a) : a;
            ub_reg  <= b[WORD_BITS-1] ? (64'd0 - b) : b;
            neg_reg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_next;
        if (fin_reg)
            res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ----- design/adcu_div.sv -----
module adcu_div
    import adcu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] an,
    input  logic [WORD_BITS-1:0] ad,
    output logic                 done,
    output logic [FRAC_BITS-1:0] k
);

    localparam int CW = $clog2(FRAC_BITS);

    logic [WORD_BITS:0]   sum_reg;
    logic [WORD_BITS:0]   rem_reg;
    logic [WORD_BITS+1:0] r2;
    logic [FRAC_BITS-1:0] k_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg, done_reg;

    assign r2 = {rem_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(FRAC_BITS-1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(FRAC_BITS-1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= {1'b0, an} + {1'b0, ad};
            rem_reg <= {1'b0, an};
            k_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (r2 >= {1'b0, sum_reg})
            begin
                rem_reg <= (WORD_BITS+1)'(r2 - {1'b0, sum_reg});
                k_reg   <= {k_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= r2[WORD_BITS:0];
                k_reg   <= {k_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign k    = k_reg;

endmodule

// ----- design/adcu_datapath.sv -----
module adcu_datapath
    import adcu_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output stat_t                        stat,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         axis,
    input  logic                         near_edge,
    input  logic signed [VALUE_BITS-1:0] s_minus2,
    input  logic signed [VALUE_BITS-1:0] s_minus1,
    input  logic signed [VALUE_BITS-1:0] s_center,
    input  logic signed [VALUE_BITS-1:0] s_plus1,
    input  logic signed [VALUE_BITS-1:0] s_plus2,
    input  logic signed [VALUE_BITS-1:0] vel_neg,
    input  logic signed [VALUE_BITS-1:0] vel_pos,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic signed [VALUE_BITS-1:0] new_value,
    output logic                         saturated
);

    localparam word_t VMAX = (64'sd1 <<< (VALUE_BITS-1)) - 64'sd1;
    localparam word_t VMIN = -VMAX - 64'sd1;

    logic [SCH_BITS-1:0]   scheme_reg;
    logic [PARAM_BITS-1:0] time_step_reg, diffusivity_reg, inv_dx_reg, inv_dy_reg;

    word_t m2_reg, m1_reg, c_reg, p1_reg, p2_reg, vn_reg, vp_reg;
    logic  is_y_reg, edge_reg;
    logic [SCH_BITS-1:0] sch_reg;
    word_t fp_reg, fn_reg, den_p_reg, den_n_reg;
    logic [WORD_BITS-1:0] an_p_reg, ad_p_reg, an_n_reg, ad_n_reg;
    logic  vlp_reg, vln_reg;
    word_t r1_reg, r2_reg, conv_reg;
    logic signed [HELD_BITS-1:0] term_reg, held_reg;
    logic signed [VALUE_BITS-1:0] nv_reg, new_value_reg;
    logic  sat_reg, saturated_reg, out_valid_reg;

    logic [SCH_BITS-1:0] sch_eff;
    logic  vp_pos, vn_pos;
    word_t u2p, up, dnp, u2n, un, dnn, den_p, num_p, den_n, num_n;
    word_t fp_init, fn_init, h, lap, diff_t, nv_full;
    logic  act_p, act_n;
    word_t mul_a, mul_b, mul_res;
    logic  mul_done, div_done;
    logic [FRAC_BITS-1:0] k;
    word_t kw;

    // configuration registers, written masked to their width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg      <= SCH_CENTRAL;
            time_step_reg   <= PARAM_BITS'(655);
            diffusivity_reg <= PARAM_BITS'(65536);
            inv_dx_reg      <= PARAM_BITS'(65536);
            inv_dy_reg      <= PARAM_BITS'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCHEME:      scheme_reg      <= cfg_data[SCH_BITS-1:0];
                REG_TIME_STEP:   time_step_reg   <= cfg_data[PARAM_BITS-1:0];
                REG_DIFFUSIVITY: diffusivity_reg <= cfg_data[PARAM_BITS-1:0];
                REG_INV_DX:      inv_dx_reg      <= cfg_data[PARAM_BITS-1:0];
                REG_INV_DY:      inv_dy_reg      <= cfg_data[PARAM_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // face preparation from the captured stencil
    always_comb
    begin
        sch_eff = (edge_reg && scheme_reg[1]) ? SCH_UPWIND : scheme_reg;
        vp_pos  = vp_reg > 0;
        vn_pos  = vn_reg > 0;
        u2p     = vp_pos ? m1_reg : p2_reg;
        up      = vp_pos ? c_reg  : p1_reg;
        dnp     = vp_pos ? p1_reg : c_reg;
        u2n     = vn_pos ? m2_reg : p1_reg;
        un      = vn_pos ? m1_reg : c_reg;
        dnn     = vn_pos ? c_reg  : m1_reg;
        den_p   = dnp - up;
        num_p   = up - u2p;
        den_n   = dnn - un;
        num_n   = un - u2n;
        act_p   = (den_p != 0) && (num_p != 0) && (num_p[WORD_BITS-1] == den_p[WORD_BITS-1]);
        act_n   = (den_n != 0) && (num_n != 0) && (num_n[WORD_BITS-1] == den_n[WORD_BITS-1]);
        unique case (sch_eff)
            SCH_UPWIND:
            begin
                fp_init = vp_pos ? c_reg : p1_reg;
                fn_init = vn_pos ? m1_reg : c_reg;
            end
            SCH_QUICK:
            begin
                fp_init = vp_pos ? quick_face(c_reg, p1_reg, m1_reg)
                                 : quick_face(p1_reg, c_reg, p2_reg);
                fn_init = vn_pos ? quick_face(m1_reg, c_reg, m2_reg)
                                 : quick_face(c_reg, m1_reg, p1_reg);
            end
            SCH_TVD:
            begin
                fp_init = up;
                fn_init = un;
            end
            default:
            begin
                fp_init = '0;
                fn_init = '0;
            end
        endcase
    end

    assign h   = is_y_reg ? word_t'({33'd0, inv_dy_reg}) : word_t'({33'd0, inv_dx_reg});
    assign lap = p1_reg - (c_reg <<< 1) + m1_reg;
    assign kw  = word_t'({{(WORD_BITS-FRAC_BITS){1'b0}}, k});

    // multiplier operand selection
    always_comb
    begin
        unique case (cmd.mul_op)
            MOP_VFP:
            begin
                mul_a = kw;
                mul_b = den_p_reg;
            end
            MOP_VFN:
            begin
                mul_a = kw;
                mul_b = den_n_reg;
            end
            MOP_CP1:
            begin
                mul_a = vp_reg;
                mul_b = (sch_reg == SCH_CENTRAL) ? c_reg + p1_reg : fp_reg;
            end
            MOP_CP2:
            begin
                mul_a = vn_reg;
                mul_b = (sch_reg == SCH_CENTRAL) ? m1_reg + c_reg : fn_reg;
            end
            MOP_MH:
            begin
                mul_a = h;
                mul_b = sat_sub(r1_reg, r2_reg);
            end
            MOP_HH:
            begin
                mul_a = h;
                mul_b = h;
            end
            MOP_COEF:
            begin
                mul_a = word_t'({33'd0, diffusivity_reg});
                mul_b = r1_reg;
            end
            MOP_DIFF:
            begin
                mul_a = r1_reg;
                mul_b = lap;
            end
            MOP_TS:
            begin
                mul_a = word_t'({33'd0, time_step_reg});
                mul_b = WORD_BITS'(held_reg) + WORD_BITS'(term_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    adcu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    adcu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .an    (cmd.div_neg ? an_n_reg : an_p_reg),
        .ad    (cmd.div_neg ? ad_n_reg : ad_p_reg),
        .done  (div_done),
        .k     (k)
    );

    assign diff_t  = clamp_held(sat_sub(conv_reg, mul_res));
    assign nv_full = sat_sub(c_reg, mul_res);

    // held x term is architectural state and resets to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (mul_done && cmd.mul_op == MOP_DIFF && !is_y_reg)
            held_reg <= diff_t[HELD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            m2_reg   <= WORD_BITS'(s_minus2);
            m1_reg   <= WORD_BITS'(s_minus1);
            c_reg    <= WORD_BITS'(s_center);
            p1_reg   <= WORD_BITS'(s_plus1);
            p2_reg   <= WORD_BITS'(s_plus2);
            vn_reg   <= WORD_BITS'(vel_neg);
            vp_reg   <= WORD_BITS'(vel_pos);
            is_y_reg <= axis;
            edge_reg <= near_edge;
        end
        if (cmd.prep)
        begin
            sch_reg   <= sch_eff;
            fp_reg    <= fp_init;
            fn_reg    <= fn_init;
            den_p_reg <= den_p;
            den_n_reg <= den_n;
            an_p_reg  <= num_p[WORD_BITS-1] ? 64'd0 - num_p : num_p;
            ad_p_reg  <= den_p[WORD_BITS-1] ? 64'd0 - den_p : den_p;
            an_n_reg  <= num_n[WORD_BITS-1] ? 64'd0 - num_n : num_n;
            ad_n_reg  <= den_n[WORD_BITS-1] ? 64'd0 - den_n : den_n;
            vlp_reg   <= act_p;
            vln_reg   <= act_n;
        end
        if (mul_done)
        begin
            unique case (cmd.mul_op)
                MOP_VFP:  fp_reg   <= sat_add(fp_reg, mul_res);
                MOP_VFN:  fn_reg   <= sat_add(fn_reg, mul_res);
                MOP_CP1:  r1_reg   <= mul_res;
                MOP_CP2:  r2_reg   <= mul_res;
                MOP_MH:   conv_reg <= (sch_reg == SCH_CENTRAL) ? (mul_res >>> 1) : mul_res;
                MOP_HH:   r1_reg   <= mul_res;
                MOP_COEF: r1_reg   <= mul_res;
                MOP_DIFF: term_reg <= diff_t[HELD_BITS-1:0];
                MOP_TS:
                begin
                    if (nv_full > VMAX)
                    begin
                        nv_reg  <= VMAX[VALUE_BITS-1:0];
                        sat_reg <= 1'b1;
                    end
                    else if (nv_full < VMIN)
                    begin
                        nv_reg  <= VMIN[VALUE_BITS-1:0];
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        nv_reg  <= nv_full[VALUE_BITS-1:0];
                        sat_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.out_load)
        begin
            new_value_reg <= nv_reg;
            saturated_reg <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign stat.tvd_p    = (sch_reg == SCH_TVD) && vlp_reg;
    assign stat.tvd_n    = (sch_reg == SCH_TVD) && vln_reg;
    assign stat.is_y     = is_y_reg;
    assign stat.mul_done = mul_done;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign new_value = new_value_reg;
    assign saturated = saturated_reg;

endmodule

// ----- design/adcu_ctrl.sv -----
module adcu_ctrl
    import adcu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output cmd_t  cmd,
    input  stat_t stat
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_DIVP  = 4'd2;
    localparam logic [3:0] ST_MULVP = 4'd3;
    localparam logic [3:0] ST_DIVN  = 4'd4;
    localparam logic [3:0] ST_MULVN = 4'd5;
    localparam logic [3:0] ST_CP1   = 4'd6;
    localparam logic [3:0] ST_CP2   = 4'd7;
    localparam logic [3:0] ST_MH    = 4'd8;
    localparam logic [3:0] ST_HH    = 4'd9;
    localparam logic [3:0] ST_COEF  = 4'd10;
    localparam logic [3:0] ST_DIFF  = 4'd11;
    localparam logic [3:0] ST_TS    = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    logic [3:0] state_reg, state_next, after;
    logic       issued_reg, issued_next, use_mul;

    always_comb
    begin
        cmd         = '0;
        cmd.mul_op  = MOP_VFP;
        state_next  = state_reg;
        issued_next = issued_reg;
        use_mul     = 1'b0;
        after       = ST_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIVP;
            end
            ST_DIVP, ST_DIVN:
            begin
                cmd.div_neg = (state_reg == ST_DIVN);
                if (!(cmd.div_neg ? stat.tvd_n : stat.tvd_p))
                    state_next = cmd.div_neg ? ST_CP1 : ST_DIVN;
                else if (!issued_reg)
                begin
                    cmd.div_start = 1'b1;
                    issued_next   = 1'b1;
                end
                else if (stat.div_done)
                begin
                    issued_next = 1'b0;
                    state_next  = cmd.div_neg ? ST_MULVN : ST_MULVP;
                end
            end
            ST_MULVP:
            begin
                use_mul    = 1'b1;
                cmd.mul_op = MOP_VFP;
                after      = ST_DIVN;
            end
            ST_MULVN:
            begin
                use_mul    = 1'b1;
                cmd.mul_op = MOP_VFN;
                after      = ST_CP1;
            end
            ST_CP1:
            begin
                use_mul    = 1'b1;
                cmd.mul_op = MOP_CP1;
                after      = ST_CP2;
            end
            ST_CP2:
            begin
                use_mul    = 1'b1;
                cmd.mul_op = MOP_CP2;
                after      = ST_MH;
            end
            ST_MH:
            begin
                use_mul    = 1'b1;
                cmd.mul_op = MOP_MH;
                after      = ST_HH;
            end
            ST_HH:
            begin
                use_mul    = 1'b1;
                cmd.mul_op = MOP_HH;
                after      = ST_COEF;
            end
            ST_COEF:
            begin
                use_mul    = 1'b1;
                cmd.mul_op = MOP_COEF;
                after      = ST_DIFF;
            end
            ST_DIFF:
            begin
                use_mul    = 1'b1;
                cmd.mul_op = MOP_DIFF;
                after      = stat.is_y ? ST_TS : ST_IDLE;
            end
            ST_TS:
            begin
                use_mul    = 1'b1;
                cmd.mul_op = MOP_TS;
                after      = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // issue the multiply once, then wait for its result
        if (use_mul)
        begin
            if (!issued_reg)
            begin
                cmd.mul_start = 1'b1;
                issued_next   = 1'b1;
            end
            else if (stat.mul_done)
            begin
                issued_next = 1'b0;
                state_next  = after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ----- design/advection_diffusion_cell_update.sv -----
// Explicit one-cell update of a 2D advection-diffusion equation in signed
// fixed point (VALUE_BITS wide, FRAC_BITS fraction bits). Send each cell as
// an x item (axis 0), whose convection-minus-diffusion term is held, then a
// y item (axis 1), which yields one item: center - time_step * (x term + y
// term), clipped to range with saturated set on a clip. The scheme register
// picks central, upwind, QUICK or Van Leer convection; near_edge drops QUICK
// and Van Leer to upwind. One item is worked on at a time: in_stall stays
// high from acceptance until the work is done. All products go through one
// shared 64x64 multiplier built from four 32x32 partial products; an x item
// runs six multiplies and a y item seven. A Van Leer face with a nonzero
// limited gradient adds a bit-serial division and one more multiply. A y
// item can also wait on a stalled output before its result is loaded. A
// finished result waits in the output register while the next item is
// taken. Write configuration only when idle.
module advection_diffusion_cell_update
    import adcu_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         axis,
    input  logic                         near_edge,
    input  logic signed [VALUE_BITS-1:0] s_minus2,
    input  logic signed [VALUE_BITS-1:0] s_minus1,
    input  logic signed [VALUE_BITS-1:0] s_center,
    input  logic signed [VALUE_BITS-1:0] s_plus1,
    input  logic signed [VALUE_BITS-1:0] s_plus2,
    input  logic signed [VALUE_BITS-1:0] vel_neg,
    input  logic signed [VALUE_BITS-1:0] vel_pos,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] new_value,
    output logic                         saturated
);

    cmd_t  cmd;
    stat_t stat;

    // configuration is always taken and lands at once; write it only while idle
    assign cfg_ready = 1'b1;

    adcu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    adcu_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .axis      (axis),
        .near_edge (near_edge),
        .s_minus2  (s_minus2),
        .s_minus1  (s_minus1),
        .s_center  (s_center),
        .s_plus1   (s_plus1),
        .s_plus2   (s_plus2),
        .vel_neg   (vel_neg),
        .vel_pos   (vel_pos),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .new_value (new_value),
        .saturated (saturated)
    );

endmodule

// ----- design/adcu_checker.sv -----
module adcu_checker
#(
    parameter int VALUE_BITS = 32
)(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [VALUE_BITS-1:0] new_value,
    input logic                         saturated
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(new_value) && $stable(saturated))
        else $error("stalled result changed");

    // one item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    // a clipped result sits on a range limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            new_value == {1'b0, {(VALUE_BITS-1){1'b1}}} ||
            new_value == {1'b1, {(VALUE_BITS-1){1'b0}}})
        else $error("saturated result not at a limit");

endmodule

bind advection_diffusion_cell_update adcu_checker #(.VALUE_BITS(VALUE_BITS)) u_adcu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_value (new_value),
    .saturated (saturated)
);
